// File: design/gsdf_pkg.sv
package gsdf_pkg;

  localparam int SpeedW = 16;
  localparam int AlphaW = 9;
  localparam int SatsW  = 6;
  localparam int AddrW  = 5;
  localparam int DataW  = 32;

  // Full-scale EMA weight, Q1.8 1.0
  localparam logic [AlphaW-1:0] AlphaOne = 9'd256;

  // Register map, word index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_GPS_ENABLED       = 3'd0,
    REG_SMOOTHING_ALPHA   = 3'd1,
    REG_MIN_SPEED         = 3'd2,
    REG_MIN_RELIABLE_SATS = 3'd3,
    REG_UNLOCK_SPEED      = 3'd4,
    REG_RELOCK_SPEED      = 3'd5,
    REG_POOR_SIGNAL_CAP   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic              gps_enabled;
    logic [AlphaW-1:0] smoothing_alpha;
    logic [SpeedW-1:0] min_speed;
    logic [SatsW-1:0]  min_reliable_sats;
    logic [SpeedW-1:0] unlock_speed;
    logic [SpeedW-1:0] relock_speed;
    logic [SpeedW-1:0] poor_signal_cap;
  } cfg_t;

  typedef struct packed {
    logic              fix_valid;
    logic [SpeedW-1:0] raw_speed;
    logic [SatsW-1:0]  used_sats;
    logic              stationary_hint;
  } fix_t;

  typedef struct packed {
    logic              fix_accepted;
    logic [SpeedW-1:0] reported_speed;
    logic              motion_detected;
  } speed_t;

endpackage

// File: design/gsdf_regs.sv
module gsdf_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gsdf_pkg::AddrW-1:0]    paddr,
  input  logic [gsdf_pkg::DataW-1:0]    pwdata,
  output logic [gsdf_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  output gsdf_pkg::cfg_t                cfg
);

  logic              wr_en;
  gsdf_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = gsdf_pkg::reg_idx_t'(paddr[4:2]);

  // Register writes; addresses past the map are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gps_enabled       <= 1'b0;
      cfg.smoothing_alpha   <= 9'd128;
      cfg.min_speed         <= 16'd16;
      cfg.min_reliable_sats <= 6'd4;
      cfg.unlock_speed      <= 16'd40;
      cfg.relock_speed      <= 16'd8;
      cfg.poor_signal_cap   <= 16'd80;
    end else if (wr_en) begin
      case (idx)
        gsdf_pkg::REG_GPS_ENABLED:       cfg.gps_enabled       <= pwdata[0];
        gsdf_pkg::REG_SMOOTHING_ALPHA:   cfg.smoothing_alpha   <= pwdata[8:0];
        gsdf_pkg::REG_MIN_SPEED:         cfg.min_speed         <= pwdata[15:0];
        gsdf_pkg::REG_MIN_RELIABLE_SATS: cfg.min_reliable_sats <= pwdata[5:0];
        gsdf_pkg::REG_UNLOCK_SPEED:      cfg.unlock_speed      <= pwdata[15:0];
        gsdf_pkg::REG_RELOCK_SPEED:      cfg.relock_speed      <= pwdata[15:0];
        gsdf_pkg::REG_POOR_SIGNAL_CAP:   cfg.poor_signal_cap   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    case (idx)
      gsdf_pkg::REG_GPS_ENABLED:       prdata = {31'd0, cfg.gps_enabled};
      gsdf_pkg::REG_SMOOTHING_ALPHA:   prdata = {23'd0, cfg.smoothing_alpha};
      gsdf_pkg::REG_MIN_SPEED:         prdata = {16'd0, cfg.min_speed};
      gsdf_pkg::REG_MIN_RELIABLE_SATS: prdata = {26'd0, cfg.min_reliable_sats};
      gsdf_pkg::REG_UNLOCK_SPEED:      prdata = {16'd0, cfg.unlock_speed};
      gsdf_pkg::REG_RELOCK_SPEED:      prdata = {16'd0, cfg.relock_speed};
      gsdf_pkg::REG_POOR_SIGNAL_CAP:   prdata = {16'd0, cfg.poor_signal_cap};
      default:                         prdata = '0;
    endcase
  end

endmodule

// File: design/gsdf_core.sv
module gsdf_core (
  input  logic              clk,
  input  logic              rst,
  input  gsdf_pkg::cfg_t    cfg,
  input  gsdf_pkg::fix_t    fix,
  input  logic              advance,
  output gsdf_pkg::speed_t  res
);

  // Filter state
  logic [15:0] smoothed;
  logic [15:0] smoothed_next;
  logic        motion;
  logic        motion_next;

  logic        take;
  logic [8:0]  alpha;
  logic signed [16:0] diff;
  logic signed [26:0] prod;
  logic signed [26:0] acc;
  logic [15:0] ema;
  logic        motion_new;
  logic        still;
  logic [16:0] thr;
  logic        below_thr;
  logic        poor;

  assign take = cfg.gps_enabled && fix.fix_valid;

  // EMA as s + a*(raw - s) >> 8: one signed multiply, floor of a non-negative sum
  assign alpha = (cfg.smoothing_alpha > gsdf_pkg::AlphaOne) ? gsdf_pkg::AlphaOne
                                                           : cfg.smoothing_alpha;
  assign diff  = $signed({1'b0, fix.raw_speed}) - $signed({1'b0, smoothed});
  assign prod  = 27'(diff) * 27'($signed({1'b0, alpha}));
  assign acc   = $signed({3'b000, smoothed, 8'd0}) + prod;
  assign ema   = acc[23:8];

  // Motion flag with hysteresis; the set test wins over the clear test, and the flag holds when neither fires
  always_comb begin
    motion_new = motion;
    priority if (fix.raw_speed > cfg.unlock_speed) begin
      motion_new = 1'b1;
    end else if (fix.raw_speed < cfg.relock_speed) begin
      motion_new = 1'b0;
    end else begin
      motion_new = motion;
    end
  end

  assign still     = fix.stationary_hint && !motion_new;
  assign thr       = still ? {cfg.min_speed, 1'b0} : {1'b0, cfg.min_speed};
  assign below_thr = {1'b0, ema} < thr;
  assign poor      = still && (fix.used_sats < cfg.min_reliable_sats)
                     && (ema < cfg.poor_signal_cap);

  // Result and next state
  always_comb begin
    smoothed_next       = smoothed;
    motion_next         = motion;
    res.fix_accepted    = 1'b0;
    res.reported_speed  = '0;
    res.motion_detected = motion;
    if (take) begin
      motion_next         = motion_new;
      res.fix_accepted    = 1'b1;
      res.motion_detected = motion_new;
      priority if (below_thr) begin
        smoothed_next = '0;
      end else if (poor) begin
        smoothed_next = ema;
      end else begin
        smoothed_next      = ema;
        res.reported_speed = ema;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed <= '0;
      motion   <= 1'b0;
    end else if (advance) begin
      smoothed <= smoothed_next;
      motion   <= motion_next;
    end
  end

endmodule

// File: design/gps_speed_drift_filter.sv
// GPS speed drift filter. One item per cycle sustained while the result output is
// not stalled: each fix is registered in the input register on acceptance and
// then passes through the EMA multiply, the motion hysteresis and the zero-speed
// tests into the result register once that register is free.
// The smoothed speed and motion flag are updated as each fix leaves the input
// register, which closes the per-fix dependency. Registers sit at byte
// addresses 4*i (gps_enabled at 0 up to poor_signal_cap at 24); the user must
// write them only while no item is in flight, as the block does not enforce it.
module gps_speed_drift_filter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gsdf_pkg::AddrW-1:0]    paddr,
  input  logic [gsdf_pkg::DataW-1:0]    pwdata,
  output logic [gsdf_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  gsdf_pkg::fix_t                sample,
  output logic                          result_valid,
  input  logic                          result_stall,
  output gsdf_pkg::speed_t              result
);

  gsdf_pkg::cfg_t   cfg;
  gsdf_pkg::fix_t   fix;
  gsdf_pkg::speed_t res;
  logic             fix_vld;
  logic             advance;

  gsdf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gsdf_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .fix     (fix),
    .advance (advance),
    .res     (res)
  );

  // Handshake: input register moves on when the result register is free
  assign advance      = fix_vld && (!result_valid || !result_stall);
  assign sample_stall = fix_vld && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      fix_vld <= 1'b0;
    end else if (!sample_stall) begin
      fix_vld <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!sample_stall && sample_valid) begin
      fix <= sample;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      result_valid <= fix_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= res;
    end
  end

endmodule

// File: sim/tb_gps_speed_drift_filter.sv
module tb_gps_speed_drift_filter;
  timeunit 1ns;
  timeprecision 1ps;

  import gsdf_pkg::*;

  localparam int CycleLimit = 300000;

  // Expected speed results, built from a local copy of the filter state
  class speed_checker;
    logic              gps_en;
    logic [AlphaW-1:0] alpha_cfg;
    logic [SpeedW-1:0] min_spd;
    logic [SatsW-1:0]  min_sats;
    logic [SpeedW-1:0] unlock_spd;
    logic [SpeedW-1:0] relock_spd;
    logic [SpeedW-1:0] cap_spd;
    logic [SpeedW-1:0] avg_speed;
    logic              moving;
    speed_t            pending_speeds[$];
    int                errors;
    int                checked;
    int                fixes;
    int                accepted;
    int                zeroed;
    int                poor_held;

    function new();
      gps_en     = 1'b0;
      alpha_cfg  = 9'd128;
      min_spd    = 16'd16;
      min_sats   = 6'd4;
      unlock_spd = 16'd40;
      relock_spd = 16'd8;
      cap_spd    = 16'd80;
      avg_speed  = '0;
      moving     = 1'b0;
      errors     = 0;
      checked    = 0;
      fixes      = 0;
      accepted   = 0;
      zeroed     = 0;
      poor_held  = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [DataW-1:0] v);
      case (idx)
        REG_GPS_ENABLED:       gps_en     = v[0];
        REG_SMOOTHING_ALPHA:   alpha_cfg  = v[AlphaW-1:0];
        REG_MIN_SPEED:         min_spd    = v[SpeedW-1:0];
        REG_MIN_RELIABLE_SATS: min_sats   = v[SatsW-1:0];
        REG_UNLOCK_SPEED:      unlock_spd = v[SpeedW-1:0];
        REG_RELOCK_SPEED:      relock_spd = v[SpeedW-1:0];
        REG_POOR_SIGNAL_CAP:   cap_spd    = v[SpeedW-1:0];
        default: ;
      endcase
    endfunction

    function speed_t predict_speed(fix_t f);
      speed_t            r;
      logic [AlphaW-1:0] a;
      logic [31:0]       mix;
      logic [SpeedW:0]   thr;
      logic              still;
      r.fix_accepted    = 1'b0;
      r.reported_speed  = '0;
      r.motion_detected = moving;
      // disabled receiver or bad fix: state untouched
      if (!gps_en || !f.fix_valid) return r;
      a = (alpha_cfg > AlphaOne) ? AlphaOne : alpha_cfg;
      mix = 32'(a) * 32'(f.raw_speed) + (32'd256 - 32'(a)) * 32'(avg_speed);
      avg_speed = mix[SpeedW+7:8];
      // hysteresis, set test wins
      if (f.raw_speed > unlock_spd) moving = 1'b1;
      else if (f.raw_speed < relock_spd) moving = 1'b0;
      still = f.stationary_hint && !moving;
      thr = still ? {min_spd, 1'b0} : {1'b0, min_spd};
      r.fix_accepted    = 1'b1;
      r.motion_detected = moving;
      if ({1'b0, avg_speed} < thr) begin
        avg_speed = '0;
        zeroed++;
      end else if (still && f.used_sats < min_sats && avg_speed < cap_spd) begin
        poor_held++;
      end else begin
        r.reported_speed = avg_speed;
      end
      return r;
    endfunction

    function void note_fix(fix_t f);
      speed_t e;
      e = predict_speed(f);
      fixes++;
      if (e.fix_accepted) accepted++;
      pending_speeds.push_back(e);
    endfunction

    function void check_speed(speed_t got);
      speed_t e;
      if (pending_speeds.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: acc=%0b spd=%0d mot=%0b",
                   got.fix_accepted, got.reported_speed, got.motion_detected);
        return;
      end
      e = pending_speeds.pop_front();
      checked++;
      if (got.fix_accepted !== e.fix_accepted || got.reported_speed !== e.reported_speed ||
          got.motion_detected !== e.motion_detected) begin
        errors++;
        if (errors <= 10)
          $display("mismatch on result %0d: expected acc=%0b spd=%0d mot=%0b, %s",
                   checked, e.fix_accepted, e.reported_speed, e.motion_detected,
                   $sformatf("got acc=%0b spd=%0d mot=%0b", got.fix_accepted,
                             got.reported_speed, got.motion_detected));
      end
    endfunction

    function int pending();
      return pending_speeds.size();
    endfunction
  endclass

  logic             clk;
  logic             rst          = 1'b1;
  logic             psel         = 1'b0;
  logic             penable      = 1'b0;
  logic             pwrite       = 1'b0;
  logic [AddrW-1:0] paddr        = '0;
  logic [DataW-1:0] pwdata       = '0;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             sample_valid = 1'b0;
  logic             sample_stall;
  fix_t             sample       = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  speed_t           result;

  speed_checker sb;
  int           cycles   = 0;
  int           settings = 0;

  gps_speed_drift_filter u_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // monitor both channels, drive receiver stall, watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (sample_valid && !sample_stall) sb.note_fix(sample);
      if (result_valid && !result_stall) sb.check_speed(result);
    end
    case (cycles[9:8])
      2'd0: result_stall <= 1'b0;
      2'd1: result_stall <= ($urandom_range(0, 3) == 0);
      2'd2: result_stall <= ($urandom_range(0, 3) != 0);
      default: result_stall <= cycles[2];
    endcase
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  task automatic apb_write(input reg_idx_t idx, input logic [DataW-1:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic send_fix(input fix_t f);
    sample       <= f;
    sample_valid <= 1'b1;
    do @(posedge clk); while (sample_stall);
  endtask

  task automatic idle(input int n);
    sample_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // let the monitor note the last accepted item before polling the queue
  task automatic wait_for_results();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // drain, let the pipeline settle, then rewrite every register
  task automatic apply_settings(input logic [DataW-1:0] en, alpha, mins, sats,
                                input logic [DataW-1:0] unl, rel, cap);
    wait_for_results();
    repeat (3) @(posedge clk);
    apb_write(REG_GPS_ENABLED, en);
    apb_write(REG_SMOOTHING_ALPHA, alpha);
    apb_write(REG_MIN_SPEED, mins);
    apb_write(REG_MIN_RELIABLE_SATS, sats);
    apb_write(REG_UNLOCK_SPEED, unl);
    apb_write(REG_RELOCK_SPEED, rel);
    apb_write(REG_POOR_SIGNAL_CAP, cap);
    settings++;
  endtask

  function automatic fix_t mk_fix(logic v, logic [SpeedW-1:0] spd, logic [SatsW-1:0] sats,
                                  logic hint);
    fix_t f;
    f.fix_valid       = v;
    f.raw_speed       = spd;
    f.used_sats       = sats;
    f.stationary_hint = hint;
    return f;
  endfunction

  function automatic logic [SpeedW-1:0] near(int centre, int span);
    int v;
    v = centre - span + int'($urandom_range(0, 2 * span));
    if (v < 0) return '0;
    if (v > 65535) return 16'hFFFF;
    return v[SpeedW-1:0];
  endfunction

  // speeds aimed mostly at thresholds and the running average
  function automatic fix_t random_fix();
    fix_t f;
    f.fix_valid       = ($urandom_range(0, 9) != 0);
    f.stationary_hint = 1'($urandom_range(0, 1));
    f.used_sats       = $urandom_range(0, 1) ? SatsW'($urandom_range(0, 63))
                                             : SatsW'(near(sb.min_sats, 2));
    case ($urandom_range(0, 9))
      0, 1:    f.raw_speed = SpeedW'($urandom_range(0, 65535));
      2:       f.raw_speed = SpeedW'($urandom_range(0, 255));
      3:       f.raw_speed = near($urandom_range(0, 1) ? 2 * sb.min_spd : sb.min_spd, 16);
      4:       f.raw_speed = near(sb.unlock_spd, 8);
      5:       f.raw_speed = near(sb.relock_spd, 8);
      6:       f.raw_speed = near(sb.cap_spd, 8);
      default: f.raw_speed = near(sb.avg_speed, 64);
    endcase
    return f;
  endfunction

  task automatic run_random(input int n);
    int sent;
    int burst;
    int gap;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 48);
      for (int k = 0; k < burst && sent < n; k++) begin
        send_fix(random_fix());
        sent++;
      end
      if ($urandom_range(0, 19) == 0) begin
        wait_for_results();
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) idle(gap);
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // receiver still disabled after reset
    send_fix(mk_fix(1'b1, 16'd500, 6'd10, 1'b0));
    send_fix(mk_fix(1'b0, 16'd500, 6'd10, 1'b1));

    // alpha above full scale, so the average follows the raw speed
    apply_settings(1, 511, 16, 4, 100, 8, 80);
    send_fix(mk_fix(1'b0, 16'hFFFF, 6'd63, 1'b1));
    send_fix(mk_fix(1'b1, 16'd0, 6'd0, 1'b0));
    send_fix(mk_fix(1'b1, 16'hFFFF, 6'd63, 1'b0));
    send_fix(mk_fix(1'b1, 16'd50, 6'd0, 1'b1));   // between relock and unlock: hold
    send_fix(mk_fix(1'b1, 16'd4, 6'd10, 1'b0));   // relock, below threshold
    send_fix(mk_fix(1'b1, 16'd50, 6'd2, 1'b1));   // poor stationary fix, state kept
    send_fix(mk_fix(1'b1, 16'd20, 6'd2, 1'b1));   // under doubled threshold
    send_fix(mk_fix(1'b1, 16'd31, 6'd10, 1'b1));
    send_fix(mk_fix(1'b1, 16'd32, 6'd10, 1'b1));
    send_fix(mk_fix(1'b1, 16'd16, 6'd10, 1'b0));
    send_fix(mk_fix(1'b1, 16'd15, 6'd10, 1'b0));
    send_fix(mk_fix(1'b1, 16'd80, 6'd3, 1'b1));   // right at the cap
    apply_settings(1, 0, 16, 4, 100, 8, 80);
    send_fix(mk_fix(1'b1, 16'hFFFF, 6'd63, 1'b0));
    apply_settings(1, 1, 16, 4, 100, 8, 80);
    send_fix(mk_fix(1'b1, 16'hFFFF, 6'd63, 1'b0));
    apply_settings(1, 256, 0, 63, 100, 200, 65535);  // relock above unlock
    send_fix(mk_fix(1'b1, 16'd150, 6'd0, 1'b1));
    send_fix(mk_fix(1'b1, 16'd50, 6'd0, 1'b1));
    send_fix(mk_fix(1'b1, 16'hFFFF, 6'd0, 1'b1));

    // random phases over a spread of settings
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: apply_settings(1, 128, 16, 4, 40, 8, 80);
        1: apply_settings(1, 256, 0, 0, 0, 0, 0);
        2: apply_settings(1, 511, 65535, 63, 65535, 65535, 65535);
        3: apply_settings(1, 255, 32, 8, 200, 50, 400);
        5: apply_settings(1, 64, 24, 6, 60, 300, 500);
        6: apply_settings(0, $urandom_range(0, 511), 16, 4, 40, 8, 80);
        default: apply_settings(1, $urandom_range(0, 511), $urandom_range(0, 400),
                                $urandom_range(0, 63), $urandom_range(0, 800),
                                $urandom_range(0, 800), $urandom_range(0, 1200));
      endcase
      run_random(p == 6 ? 100 : 255);
    end

    wait_for_results();
    repeat (8) @(posedge clk);
    $display("covered %0d fixes over %0d register settings: %0d accepted,",
             sb.fixes, settings, sb.accepted);
    $display("%0d forced to zero, %0d poor-signal zero reports; %0d checked, %0d failures",
             sb.zeroed, sb.poor_held, sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
